// ===== hw/rtl/matrix_multiply_engine_core_assert.svh =====
// Assertion macros for the matrix multiply engine RTL, included by mme_ctrl.
// Every check is clocked on clk and held off while rst_n is low.
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge.
`define MME_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define MME_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define MME_ASSERT_ALWAYS(label, expr, msg)
`define MME_ASSERT_IMPLIES(label, ante, cons, msg)
`define MME_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/mme_pkg.sv =====
package mme_pkg;

  // Field widths of the streams and the register file.
  localparam int DIM_W       = 4;
  localparam int AREA_W      = 2 * DIM_W;
  localparam int PROD_W      = 37;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int CNT_W       = 10;
  localparam int IN_W        = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_W   = 2;

  // Bit positions of the result fields inside out_tdata.
  localparam int OFS_ROW = PROD_W;
  localparam int OFS_COL = OFS_ROW + ROW_W;
  localparam int OFS_CNT = OFS_COL + COL_W;
  localparam int OUT_PAD = OUT_TDATA_W - (OFS_CNT + CNT_W);

  // Register indexes and reset value of the dimension registers.
  localparam logic [REG_IDX_W-1:0] REG_ROWS_FIRST  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS_FIRST  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROWS_SECOND = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_COLS_SECOND = 2'd3;
  localparam logic [DIM_W-1:0]     DIM_RESET       = 4'd2;

  // Matrix dimensions after clamping to the supported range.
  typedef struct packed {
    logic [DIM_W-1:0] rows_first;
    logic [DIM_W-1:0] cols_first;
    logic [DIM_W-1:0] rows_second;
    logic [DIM_W-1:0] cols_second;
  } dims_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_wr;
    logic             load_second;
    logic             issue;
    logic             first;
    logic             run_init;
    logic             next_col;
    logic             next_row;
    logic             out_result;
    logic             out_error;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/mme_regs.sv =====
module mme_regs
  import mme_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output dims_t             eff_dims,
  output logic              cfg_wr
);

  logic [DIM_W-1:0]     rows_first_r;
  logic [DIM_W-1:0]     cols_first_r;
  logic [DIM_W-1:0]     rows_second_r;
  logic [DIM_W-1:0]     cols_second_r;
  logic [REG_IDX_W-1:0] reg_idx;

  // A zero acts as one and anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  // Register writes in the access phase of a write request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_first_r  <= DIM_RESET;
      cols_first_r  <= DIM_RESET;
      rows_second_r <= DIM_RESET;
      cols_second_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROWS_FIRST:  rows_first_r  <= pwdata[DIM_W-1:0];
        REG_COLS_FIRST:  cols_first_r  <= pwdata[DIM_W-1:0];
        REG_ROWS_SECOND: rows_second_r <= pwdata[DIM_W-1:0];
        REG_COLS_SECOND: cols_second_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the stored values.
  always_comb begin
    unique case (reg_idx)
      REG_ROWS_FIRST:  prdata = APB_DW'(rows_first_r);
      REG_COLS_FIRST:  prdata = APB_DW'(cols_first_r);
      REG_ROWS_SECOND: prdata = APB_DW'(rows_second_r);
      REG_COLS_SECOND: prdata = APB_DW'(cols_second_r);
      default:         prdata = '0;
    endcase
  end

  // Clamped dimensions for the rest of the block.
  assign eff_dims.rows_first  = eff_dim(rows_first_r);
  assign eff_dims.cols_first  = eff_dim(cols_first_r);
  assign eff_dims.rows_second = eff_dim(rows_second_r);
  assign eff_dims.cols_second = eff_dim(cols_second_r);

endmodule

// ===== hw/rtl/mme_datapath.sv =====
module mme_datapath
  import mme_pkg::*;
#(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16,
  parameter int POS_W         = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dims_t                  dims,
  input  dp_cmd_t                cmd,
  input  logic [POS_W-1:0]       load_pos,
  input  logic [IN_W-1:0]        in_element,
  output dp_status_t             st,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BADDR_W = $clog2(2 * DEPTH + 1);
  localparam int MC_W    = AREA_W + DIM_W;

  logic [ELEMENT_WIDTH-1:0] first_mem  [DEPTH];
  logic [ELEMENT_WIDTH-1:0] second_mem [DEPTH];
  logic [ELEMENT_WIDTH-1:0] elem;

  logic [POS_W-1:0]   a_base_r;
  logic [POS_W-1:0]   a_addr_r;
  logic [BADDR_W-1:0] b_col_r;
  logic [BADDR_W-1:0] b_addr_r;

  logic signed [ELEMENT_WIDTH-1:0]   a_rd_r;
  logic signed [ELEMENT_WIDTH-1:0]   b_rd_r;
  logic signed [2*ELEMENT_WIDTH-1:0] prod_r;
  logic signed [PROD_W-1:0]          prod_ext;
  logic signed [PROD_W-1:0]          acc_r;
  logic                              v1_r;
  logic                              f1_r;
  logic                              v2_r;
  logic                              f2_r;

  logic [AREA_W-1:0] rc_r;
  logic [CNT_W-1:0]  mc_r;

  logic              out_valid_r;
  logic [PROD_W-1:0] out_value_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_last_r;
  logic              out_status_r;

  // The element field is taken as a plain bit pattern at the stored width.
  assign elem = ELEMENT_WIDTH'(in_element);

  // Element stores: one write port for loading, one read port for the run.
  always_ff @(posedge clk) begin
    if (cmd.load_wr && !cmd.load_second) begin
      first_mem[load_pos[ADDR_W-1:0]] <= elem;
    end
    if (cmd.issue) begin
      a_rd_r <= first_mem[a_addr_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && cmd.load_second) begin
      second_mem[load_pos[ADDR_W-1:0]] <= elem;
    end
    if (cmd.issue) begin
      b_rd_r <= second_mem[b_addr_r[ADDR_W-1:0]];
    end
  end

  // Read addresses walk along a row of the first and a column of the second.
  always_ff @(posedge clk) begin
    priority if (cmd.run_init) begin
      a_base_r <= '0;
      a_addr_r <= '0;
      b_col_r  <= '0;
      b_addr_r <= '0;
    end else if (cmd.issue) begin
      a_addr_r <= a_addr_r + 1'b1;
      b_addr_r <= b_addr_r + BADDR_W'(dims.cols_second);
    end else if (cmd.next_col) begin
      a_addr_r <= a_base_r;
      b_col_r  <= b_col_r + 1'b1;
      b_addr_r <= b_col_r + 1'b1;
    end else if (cmd.next_row) begin
      a_base_r <= a_base_r + POS_W'(dims.cols_first);
      a_addr_r <= a_base_r + POS_W'(dims.cols_first);
      b_col_r  <= '0;
      b_addr_r <= '0;
    end
  end

  // Multiply stage and accumulator, tagged with the first step of each sum.
  assign prod_ext = PROD_W'(prod_r);

  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
    if (v2_r) begin
      acc_r <= f2_r ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      f1_r <= 1'b0;
      v2_r <= 1'b0;
      f2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      f1_r <= cmd.first;
      v2_r <= v1_r;
      f2_r <= f1_r;
    end
  end

  // Multiplication count of a run, built from registered small products.
  always_ff @(posedge clk) begin
    rc_r <= AREA_W'(dims.rows_first) * AREA_W'(dims.cols_second);
    mc_r <= CNT_W'(MC_W'(rc_r) * MC_W'(dims.cols_first));
  end

  // Output register: a finished result waits here until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_result || cmd.out_error) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_result) begin
      out_value_r  <= acc_r;
      out_row_r    <= cmd.row;
      out_col_r    <= cmd.col;
      out_cnt_r    <= mc_r;
      out_last_r   <= cmd.last;
      out_status_r <= 1'b0;
    end else if (cmd.out_error) begin
      out_value_r  <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      out_cnt_r    <= '0;
      out_last_r   <= 1'b0;
      out_status_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_cnt_r, out_col_r, out_row_r, out_value_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  assign st.pipe_busy = v1_r | v2_r;
  assign st.slot_free = !out_valid_r || out_tready;

endmodule

// ===== hw/rtl/mme_ctrl.sv =====
`include "matrix_multiply_engine_core_assert.svh"

module mme_ctrl
  import mme_pkg::*;
#(
  parameter int MAX_DIM = 8,
  parameter int POS_W   = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dims_t            dims,
  input  logic             cfg_wr,
  input  logic             in_tvalid,
  output logic             in_tready,
  output dp_cmd_t          cmd,
  output logic [POS_W-1:0] load_pos,
  input  dp_status_t       st
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int CMP_W = (POS_W > AREA_W) ? POS_W : AREA_W;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [POS_W-1:0] load_pos_r, load_pos_nxt;
  logic             loading_second_r, loading_second_nxt;
  logic [DIM_W-1:0] i_r, i_nxt;
  logic [DIM_W-1:0] j_r, j_nxt;
  logic [DIM_W-1:0] k_r, k_nxt;

  logic              compat;
  logic              accept;
  logic [POS_W-1:0]  pos_inc;
  logic [AREA_W-1:0] area_first;
  logic [AREA_W-1:0] area_second;
  logic              last_row;
  logic              last_col;

  // Sizes of the two matrices and the compatibility check.
  assign compat      = (dims.cols_first == dims.rows_second);
  assign area_first  = AREA_W'(dims.rows_first) * AREA_W'(dims.cols_first);
  assign area_second = AREA_W'(dims.rows_second) * AREA_W'(dims.cols_second);
  assign pos_inc     = load_pos_r + 1'b1;
  assign last_row    = (i_r == dims.rows_first - 1'b1);
  assign last_col    = (j_r == dims.cols_second - 1'b1);

  // An error answer needs the output register, a loaded element does not.
  assign in_tready = (state_r == ST_LOAD) && (compat || st.slot_free);
  assign accept    = in_tvalid && in_tready;
  assign load_pos  = load_pos_r;

  // Sequencer: load both matrices, answer shape errors, sum each element.
  always_comb begin
    state_nxt          = state_r;
    load_pos_nxt       = load_pos_r;
    loading_second_nxt = loading_second_r;
    i_nxt              = i_r;
    j_nxt              = j_r;
    k_nxt              = k_r;
    cmd                = '0;
    cmd.load_second    = loading_second_r;
    cmd.row            = ROW_W'(i_r);
    cmd.col            = COL_W'(j_r);
    cmd.last           = last_row && last_col;

    unique case (state_r)
      ST_LOAD: begin
        priority if (cfg_wr) begin
          load_pos_nxt       = '0;
          loading_second_nxt = 1'b0;
        end else if (accept && !compat) begin
          cmd.out_error = 1'b1;
        end else if (accept && !loading_second_r) begin
          cmd.load_wr = 1'b1;
          if (CMP_W'(pos_inc) >= CMP_W'(area_first)) begin
            load_pos_nxt       = '0;
            loading_second_nxt = 1'b1;
          end else begin
            load_pos_nxt = pos_inc;
          end
        end else if (accept) begin
          cmd.load_wr = 1'b1;
          if (CMP_W'(pos_inc) >= CMP_W'(area_second)) begin
            load_pos_nxt       = '0;
            loading_second_nxt = 1'b0;
            cmd.run_init       = 1'b1;
            i_nxt              = '0;
            j_nxt              = '0;
            k_nxt              = '0;
            state_nxt          = ST_ISSUE;
          end else begin
            load_pos_nxt = pos_inc;
          end
        end
      end

      ST_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.first = (k_r == '0);
        if (k_r == dims.cols_first - 1'b1) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      ST_DRAIN: begin
        if (!st.pipe_busy && st.slot_free) begin
          cmd.out_result = 1'b1;
          priority if (last_row && last_col) begin
            state_nxt = ST_LOAD;
          end else if (last_col) begin
            cmd.next_row = 1'b1;
            j_nxt        = '0;
            i_nxt        = i_r + 1'b1;
            state_nxt    = ST_ISSUE;
          end else begin
            cmd.next_col = 1'b1;
            j_nxt        = j_r + 1'b1;
            state_nxt    = ST_ISSUE;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_LOAD;
      load_pos_r       <= '0;
      loading_second_r <= 1'b0;
      i_r              <= '0;
      j_r              <= '0;
      k_r              <= '0;
    end else begin
      state_r          <= state_nxt;
      load_pos_r       <= load_pos_nxt;
      loading_second_r <= loading_second_nxt;
      i_r              <= i_nxt;
      j_r              <= j_nxt;
      k_r              <= k_nxt;
    end
  end

  // Checks on the sequencing.
  `MME_ASSERT_ALWAYS(a_pos_in_range, int'(load_pos_r) < DEPTH, "load position beyond store")
  `MME_ASSERT_IMPLIES(a_out_slot_free, cmd.out_result || cmd.out_error, st.slot_free, "result overwrites a waiting one")
  `MME_ASSERT_IMPLIES(a_sum_complete, cmd.out_result, !st.pipe_busy, "result taken before the sum is complete")
  `MME_ASSERT_NEXT(a_run_ends, cmd.out_result && cmd.last, state_r == ST_LOAD && !loading_second_r, "run does not return to loading")

endmodule

// ===== hw/rtl/matrix_multiply_engine_core.sv =====
// Loading: one element request per cycle, no result until the second matrix is complete.
// Dimension error: the answer stands in the output register in the cycle after the request.
// Run: after the final element, each product element is summed in turn by the single
// multiply-accumulate unit and waits in the output register until it is taken.
// Reset (rst_n low, synchronous): dimensions return to 2 and loading restarts at the
// first matrix; the element stores are not cleared.
module matrix_multiply_engine_core
  import mme_pkg::*;
#(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream. tdata: element[15:0]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_W-1:0]        in_tdata,
  // Result stream. tdata: product_value[36:0], row[39:37], col[42:40],
  // multiply_count[52:43], zero fill. tuser: status.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser,
  // Configuration port.
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [APB_AW-1:0]      cfg_paddr,
  input  logic [APB_DW-1:0]      cfg_pwdata,
  output logic [APB_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int POS_W = $clog2(MAX_DIM * MAX_DIM + 1);

  dims_t            dims;
  logic             cfg_wr;
  dp_cmd_t          cmd;
  dp_status_t       st;
  logic [POS_W-1:0] load_pos;

  assign cfg_pready = 1'b1;

  // Dimension registers.
  mme_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .eff_dims (dims),
    .cfg_wr   (cfg_wr)
  );

  // Controller.
  mme_ctrl #(
    .MAX_DIM (MAX_DIM),
    .POS_W   (POS_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .cfg_wr    (cfg_wr),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .load_pos  (load_pos),
    .st        (st)
  );

  // Stores, multiply-accumulate unit and output register.
  mme_datapath #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .POS_W         (POS_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .dims       (dims),
    .cmd        (cmd),
    .load_pos   (load_pos),
    .in_element (in_tdata),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== test/mme_product_check.sv =====
// Watches the element, product and register channels of the matrix multiply engine,
// predicts every product element and compares each product request field by field.
module mme_product_check
  import mme_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_W-1:0]        in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [APB_AW-1:0]      cfg_paddr,
  input  logic [APB_DW-1:0]      cfg_pwdata,
  input  logic [APB_DW-1:0]      cfg_prdata,
  input  logic                   cfg_pready,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int   MAX_DIM          = 8;
  localparam int   STORE_DEPTH      = MAX_DIM * MAX_DIM;
  localparam int   PRINT_LIMIT      = 100;
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_DIM_ERROR = 1'b1;

  // One predicted product request.
  typedef struct packed {
    logic [PROD_W-1:0] value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
    logic [CNT_W-1:0]  count;
    logic              status;
  } product_t;

  product_t               expected_products[$];
  logic [DIM_W-1:0]       dim_reg [4];
  logic signed [IN_W-1:0] first_matrix [STORE_DEPTH];
  logic signed [IN_W-1:0] second_matrix [STORE_DEPTH];
  int                     load_pos;
  bit                     on_second;
  int                     error_count = 0;

  // A register value of zero stands for one, anything above the maximum for the maximum.
  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // Takes one element request; queues its error answer or any products it completes.
  task automatic absorb_element(logic signed [IN_W-1:0] e);
    int       r1;
    int       c1;
    int       r2;
    int       c2;
    longint   sum;
    product_t p;
    r1 = clamp_dim(dim_reg[REG_ROWS_FIRST]);
    c1 = clamp_dim(dim_reg[REG_COLS_FIRST]);
    r2 = clamp_dim(dim_reg[REG_ROWS_SECOND]);
    c2 = clamp_dim(dim_reg[REG_COLS_SECOND]);
    p = '0;

    // Incompatible shapes: the element is dropped and answered with an error.
    if (c1 != r2) begin
      p.status = STATUS_DIM_ERROR;
      expected_products.push_back(p);
      return;
    end

    if (!on_second) begin
      first_matrix[load_pos] = e;
      load_pos++;
      if (load_pos >= r1 * c1) begin
        load_pos = 0;
        on_second = 1'b1;
      end
      return;
    end

    second_matrix[load_pos] = e;
    load_pos++;
    if (load_pos < r2 * c2) return;
    load_pos = 0;
    on_second = 1'b0;

    // The second matrix is complete: every product element, row by row.
    for (int i = 0; i < r1; i++) begin
      for (int j = 0; j < c2; j++) begin
        sum = 0;
        for (int k = 0; k < c1; k++) begin
          sum += longint'(first_matrix[i * c1 + k]) * longint'(second_matrix[k * c2 + j]);
        end
        p.value  = sum[PROD_W-1:0];
        p.row    = i[ROW_W-1:0];
        p.col    = j[COL_W-1:0];
        p.last   = (i == r1 - 1) && (j == c2 - 1);
        p.count  = CNT_W'(r1 * c2 * c1);
        p.status = STATUS_OK;
        expected_products.push_back(p);
      end
    end
  endtask

  // Compares one product request with the oldest prediction.
  task automatic compare_product();
    product_t want;
    if (expected_products.size() == 0) begin
      report_mismatch("product request with nothing predicted", out_tdata, 0);
      return;
    end
    want = expected_products.pop_front();
    if (out_tdata[PROD_W-1:0] !== want.value)
      report_mismatch("product_value", out_tdata[PROD_W-1:0], want.value);
    if (out_tdata[OFS_ROW +: ROW_W] !== want.row)
      report_mismatch("row", out_tdata[OFS_ROW +: ROW_W], want.row);
    if (out_tdata[OFS_COL +: COL_W] !== want.col)
      report_mismatch("col", out_tdata[OFS_COL +: COL_W], want.col);
    if (out_tdata[OFS_CNT +: CNT_W] !== want.count)
      report_mismatch("multiply_count", out_tdata[OFS_CNT +: CNT_W], want.count);
    if (out_tdata[OUT_TDATA_W-1 -: OUT_PAD] !== '0)
      report_mismatch("zero fill", out_tdata[OUT_TDATA_W-1 -: OUT_PAD], 0);
    if (out_tlast !== want.last)
      report_mismatch("last", out_tlast, want.last);
    if (out_tuser !== want.status)
      report_mismatch("status", out_tuser, want.status);
  endtask

  // Everything is sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst_n) begin
      dim_reg[REG_ROWS_FIRST]  = DIM_RESET;
      dim_reg[REG_COLS_FIRST]  = DIM_RESET;
      dim_reg[REG_ROWS_SECOND] = DIM_RESET;
      dim_reg[REG_COLS_SECOND] = DIM_RESET;
      load_pos = 0;
      on_second = 1'b0;
      expected_products.delete();
    end else begin
      // A register write restarts loading; a read must return the stored value.
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          dim_reg[cfg_paddr[APB_AW-1:2]] = cfg_pwdata[DIM_W-1:0];
          load_pos = 0;
          on_second = 1'b0;
        end else if (cfg_prdata !== APB_DW'(dim_reg[cfg_paddr[APB_AW-1:2]])) begin
          report_mismatch("register read", cfg_prdata, dim_reg[cfg_paddr[APB_AW-1:2]]);
        end
      end
      if (in_tvalid && in_tready) absorb_element(in_tdata);
      if (out_tvalid && out_tready) compare_product();
    end
    outstanding <= expected_products.size();
    mismatches <= error_count;
  end

endmodule

// ===== test/tb_matrix_multiply_engine_core.sv =====
// Drives element requests and register accesses into the matrix multiply engine,
// stalls the product side, and gives the verdict from the product check's count.
module tb_matrix_multiply_engine_core;
  import mme_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 50;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 40;
  localparam int NUM_PHASES     = 4;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [APB_AW-1:0]      cfg_paddr   = '0;
  logic [APB_DW-1:0]      cfg_pwdata  = '0;
  logic [APB_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int quiet_cycles  = 0;
  int random_items  = 0;
  int cur_r1;
  int cur_c1;
  int cur_r2;
  int cur_c2;
  bit force_cfg     = 1'b1;

  matrix_multiply_engine_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  mme_product_check product_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Product side: random stalls, or a long hold-off when the stimulus asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done < hold_requests) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // The run ends as failed once nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // One element request, after a random idle gap; valid stays high for a following request.
  task automatic send_element(logic [IN_W-1:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= e;
    do @(posedge clk); while (!in_tready);
  endtask

  // Uniform values half of the time, else 8000, 7FFF, FFFF or 0000.
  function automatic logic [IN_W-1:0] random_element();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return IN_W'($urandom);
    endcase
  endfunction

  // Stops offering elements and waits until every predicted product has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One register access: setup cycle, access cycle, then the bus goes idle.
  task automatic cfg_transfer(bit is_write, logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= is_write;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= APB_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all four dimensions once the engine is idle, each followed by a read-back.
  task automatic set_dims(logic [DIM_W-1:0] r1, logic [DIM_W-1:0] c1,
                          logic [DIM_W-1:0] r2, logic [DIM_W-1:0] c2);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_transfer(1'b1, REG_ROWS_FIRST, r1);
    cfg_transfer(1'b0, REG_ROWS_FIRST, '0);
    cfg_transfer(1'b1, REG_COLS_FIRST, c1);
    cfg_transfer(1'b0, REG_COLS_FIRST, '0);
    cfg_transfer(1'b1, REG_ROWS_SECOND, r2);
    cfg_transfer(1'b0, REG_ROWS_SECOND, '0);
    cfg_transfer(1'b1, REG_COLS_SECOND, c2);
    cfg_transfer(1'b0, REG_COLS_SECOND, '0);
  endtask

  // A dimension of one is written as zero half of the time.
  function automatic logic [DIM_W-1:0] encode_dim(int d);
    if (d == 1 && $urandom_range(1) == 1) return '0;
    return DIM_W'(d);
  endfunction

  // One random run: often new small shapes, sometimes incompatible ones,
  // and now and then a load broken off by the next register write.
  task automatic random_run();
    int n;
    if (force_cfg || $urandom_range(1) == 0) begin
      cur_r1 = $urandom_range(1, 3);
      cur_c1 = $urandom_range(1, 3);
      cur_c2 = $urandom_range(1, 3);
      cur_r2 = ($urandom_range(7) == 0) ? (cur_c1 % 3) + 1 : cur_c1;
      set_dims(encode_dim(cur_r1), encode_dim(cur_c1), encode_dim(cur_r2),
               encode_dim(cur_c2));
    end
    force_cfg = 1'b0;
    if (cur_c1 != cur_r2) begin
      n = $urandom_range(1, 3);
    end else begin
      n = cur_r1 * cur_c1 + cur_r2 * cur_c2;
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, n - 1);
        force_cfg = 1'b1;
      end
    end
    repeat (n) send_element(random_element());
    random_items += n;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values read back, then a 2x2 product of extreme elements.
    cfg_transfer(1'b0, REG_ROWS_FIRST, '0);
    cfg_transfer(1'b0, REG_COLS_FIRST, '0);
    cfg_transfer(1'b0, REG_ROWS_SECOND, '0);
    cfg_transfer(1'b0, REG_COLS_SECOND, '0);
    send_element(16'h8000);
    send_element(16'h8000);
    send_element(16'h7FFF);
    send_element(16'hFFFF);
    send_element(16'h8000);
    send_element(16'h7FFF);
    send_element(16'h8000);
    send_element(16'h0000);

    // Single elements, the second time with zero dimensions standing for one.
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    send_element(16'h7FFF);
    send_element(16'h8000);
    set_dims(4'd0, 4'd0, 4'd0, 4'd0);
    send_element(16'hFFFF);
    send_element(16'hFFFF);

    // Inner dimensions differ: every element is answered with an error.
    set_dims(4'd1, 4'd3, 4'd2, 4'd1);
    send_element(16'h0005);
    send_element(16'hFFF9);

    // A load broken off by a register write, then a full 3x1 by 1x3 run.
    set_dims(4'd2, 4'd3, 4'd3, 4'd2);
    repeat (4) send_element(random_element());
    set_dims(4'd3, 4'd1, 4'd1, 4'd3);
    repeat (6) send_element(random_element());

    // Random phases with different idling on the two sides.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      if (phase == 0) begin
        // Widest product, 8x1 by 1x8, written as zeros and values above the maximum.
        set_dims(4'd9, 4'd0, 4'd0, 4'd12);
        repeat (16) send_element(random_element());
        // Longest sum, 1x8 by 8x1.
        set_dims(4'd1, 4'd15, 4'd8, 4'd1);
        repeat (16) send_element(random_element());
        // Product side held off while whole runs keep arriving.
        set_dims(4'd2, 4'd2, 4'd2, 4'd2);
        hold_requests++;
        repeat (16) send_element(random_element());
        wait_drained();
        force_cfg = 1'b1;
      end
      while (random_items < RANDOM_ITEMS * (phase + 1) / NUM_PHASES) random_run();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
